// ===== rtl/core/mbsd_pkg.sv =====
// Shared types and constants for the moving-baseline spike detector.
package mbsd_pkg;

    // Fixed field widths of the sample and result payloads.
    localparam int COUNT_W  = 16;
    localparam int MINUTE_W = 11;
    localparam int BASE_W   = 19;
    localparam int TOTAL_W  = 11;
    localparam int CFG_W    = 16;

    // The anomaly total stops counting at its largest value.
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPIKE_MULT    = 2'd1;

    // Configuration register reset values.
    localparam logic [CFG_W-1:0] MIN_THRESHOLD_RST = 16'd5;
    localparam logic [CFG_W-1:0] SPIKE_MULT_RST    = 16'd768;

    // Configuration seen by the decision logic.
    typedef struct packed {
        logic [CFG_W-1:0] min_threshold;
        logic [CFG_W-1:0] spike_multiplier;
    } t_cfg;

endpackage

// ===== rtl/core/moving_baseline_spike_detector.sv =====
// Top level of the moving-baseline spike detector.
//
// Samples (one error count per minute plus a start-of-day flag) arrive on the
// input valid/ready channel; each accepted sample yields exactly one result
// transfer on the output valid/ready channel, in order. A sample enters the
// input register at its transfer and is evaluated combinationally; it moves
// into the output register when that register is free or being emptied, and
// its result is offered from there until it is taken. One sample per cycle
// is sustained while the receiver does not stall: the evaluation is a single
// pass of the multiplies, compares and running-sum update between the input
// and output registers. While the receiver stalls, the output register holds
// its result and the input register still takes one more sample; after that
// the input ready drops until the result is taken.
// The configuration channel is always ready; writes to the minimum threshold
// (index 0) and the Q8.8 spike multiplier (index 1) take effect at once and
// are meant to be made while no sample is in flight. Other indexes are ignored.
// Reset clears the history, window sum, minute index, anomaly total and the
// valid flags of both pipeline registers, and restores the register defaults.
module moving_baseline_spike_detector #(
    parameter int WINDOW     = 8,
    parameter int DAY_LENGTH = 1440
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Sample channel.
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [mbsd_pkg::COUNT_W-1:0]     i_error_count,
    input  logic                             i_start_of_day,
    // Result channel.
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_decision_valid,
    output logic                             o_anomaly,
    output logic [mbsd_pkg::MINUTE_W-1:0]    o_minute_index,
    output logic [mbsd_pkg::BASE_W-1:0]      o_baseline_sum,
    output logic [mbsd_pkg::TOTAL_W-1:0]     o_anomaly_total,
    // Configuration channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mbsd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbsd_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int COUNT_W = mbsd_pkg::COUNT_W;
    localparam int TOTAL_W = mbsd_pkg::TOTAL_W;
    localparam int SUM_W   = $clog2(WINDOW * 65535 + 1);
    localparam int MC_LIM  = (DAY_LENGTH > WINDOW) ? DAY_LENGTH : WINDOW;
    localparam int MC_W    = $clog2(MC_LIM + 1);

    // Configuration registers.
    mbsd_pkg::t_cfg r_cfg;

    // Input register.
    logic               r_in_valid;
    logic [COUNT_W-1:0] r_in_count;
    logic               r_in_sod;

    // Detector state.
    logic [COUNT_W-1:0] r_hist [WINDOW];
    logic [COUNT_W-1:0] n_hist [WINDOW];
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   n_sum;
    logic [MC_W-1:0]    r_minute;
    logic [MC_W-1:0]    n_minute;
    logic [TOTAL_W-1:0] r_total;
    logic [TOTAL_W-1:0] n_total;

    // Output register.
    logic                           r_out_valid;
    logic                           r_out_dvalid;
    logic                           r_out_anomaly;
    logic [mbsd_pkg::MINUTE_W-1:0]  r_out_minute;
    logic [mbsd_pkg::BASE_W-1:0]    r_out_base;
    logic [TOTAL_W-1:0]             r_out_total;

    logic               w_advance;
    logic               w_accept;
    logic [SUM_W-1:0]   w_sum;
    logic [MC_W-1:0]    w_minute;
    logic [TOTAL_W-1:0] w_total;
    logic [COUNT_W-1:0] w_oldest;
    logic               w_in_day;
    logic               w_in_window;
    logic               w_flag;

    // Pipeline handshake: the input register moves on when the output slot is free.
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;
    assign w_accept  = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_threshold    <= mbsd_pkg::MIN_THRESHOLD_RST;
            r_cfg.spike_multiplier <= mbsd_pkg::SPIKE_MULT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mbsd_pkg::CFG_MIN_THRESHOLD: r_cfg.min_threshold    <= i_cfg_data;
                mbsd_pkg::CFG_SPIKE_MULT:    r_cfg.spike_multiplier <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_count <= i_error_count;
            r_in_sod   <= i_start_of_day;
        end
    end

    // State as seen by this sample: start of day clears it first.
    assign w_sum    = r_in_sod ? '0 : r_sum;
    assign w_minute = r_in_sod ? '0 : r_minute;
    assign w_total  = r_in_sod ? '0 : r_total;
    assign w_oldest = r_in_sod ? '0 : r_hist[WINDOW-1];

    assign w_in_day    = w_minute < MC_W'(DAY_LENGTH);
    assign w_in_window = w_in_day && (w_minute >= MC_W'(WINDOW));

    mbsd_decide #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_decide (
        .i_count     (r_in_count),
        .i_sum       (w_sum),
        .i_cfg       (r_cfg),
        .i_in_window (w_in_window),
        .o_flag      (w_flag)
    );

    // Next state: the delay line shifts and the running sum swaps the oldest
    // count for the new one; past the day end everything holds.
    always_comb begin
        n_total = w_total;
        if (w_flag && (w_total != mbsd_pkg::TOTAL_MAX)) begin
            n_total = w_total + TOTAL_W'(1);
        end
        n_sum    = w_sum;
        n_minute = w_minute;
        for (int i = 0; i < WINDOW; i++) begin
            n_hist[i] = r_in_sod ? '0 : r_hist[i];
        end
        if (w_in_day) begin
            n_sum    = w_sum - SUM_W'(w_oldest) + SUM_W'(r_in_count);
            n_minute = w_minute + MC_W'(1);
            n_hist[0] = r_in_count;
            for (int i = 1; i < WINDOW; i++) begin
                n_hist[i] = r_in_sod ? '0 : r_hist[i-1];
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_hist[i] <= '0;
            end
            r_sum    <= '0;
            r_minute <= '0;
            r_total  <= '0;
        end else if (w_advance) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_hist[i] <= n_hist[i];
            end
            r_sum    <= n_sum;
            r_minute <= n_minute;
            r_total  <= n_total;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_dvalid  <= w_in_window;
            r_out_anomaly <= w_flag;
            r_out_minute  <= mbsd_pkg::MINUTE_W'(w_minute);
            r_out_base    <= mbsd_pkg::BASE_W'(w_sum);
            r_out_total   <= n_total;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_decision_valid = r_out_dvalid;
    assign o_anomaly        = r_out_anomaly;
    assign o_minute_index   = r_out_minute;
    assign o_baseline_sum   = r_out_base;
    assign o_anomaly_total  = r_out_total;

endmodule

// ===== rtl/core/mbsd_decide.sv =====
// Spike decision: compares the current count against the scaled window baseline.
module mbsd_decide #(
    parameter int WINDOW = 8,
    parameter int SUM_W  = 19
) (
    input  logic [mbsd_pkg::COUNT_W-1:0] i_count,
    input  logic [SUM_W-1:0]             i_sum,
    input  mbsd_pkg::t_cfg               i_cfg,
    input  logic                         i_in_window,
    output logic                         o_flag
);

    localparam int PROD_W = SUM_W + mbsd_pkg::CFG_W;

    logic [PROD_W-1:0] w_lhs;
    logic [PROD_W-1:0] w_rhs;
    logic              w_above_min;

    // Scaled count: count * WINDOW * 256, matching the Q8.8 gain on the sum side.
    assign w_lhs = (PROD_W'(i_count) * PROD_W'(WINDOW)) << 8;

    // Baseline sum times the Q8.8 gain.
    assign w_rhs = PROD_W'(i_sum) * PROD_W'(i_cfg.spike_multiplier);

    assign w_above_min = i_count >= i_cfg.min_threshold;

    // An empty baseline flags any count that clears the minimum.
    assign o_flag = i_in_window && w_above_min && ((i_sum == '0) || (w_lhs > w_rhs));

endmodule

// ===== verif/moving_baseline_spike_detector_test.sv =====
// Self-checking testbench for the moving-baseline spike detector.
`timescale 1ns / 1ps

module moving_baseline_spike_detector_test;

    localparam int WINDOW     = 8;
    localparam int DAY_LEN    = 1440;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_LEN   = 40;

    // Field widths taken from the shared package.
    localparam int COUNT_W   = mbsd_pkg::COUNT_W;
    localparam int MINUTE_W  = mbsd_pkg::MINUTE_W;
    localparam int BASE_W    = mbsd_pkg::BASE_W;
    localparam int TOTAL_W   = mbsd_pkg::TOTAL_W;
    localparam int CFG_W     = mbsd_pkg::CFG_W;
    localparam int CFG_IDX_W = mbsd_pkg::CFG_IDX_W;

    // Register indexes that the block does not implement.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               sod;
    } t_minute_sample;

    typedef struct packed {
        logic                dec_valid;
        logic                spike;
        logic [MINUTE_W-1:0] minute;
        logic [BASE_W-1:0]   base;
        logic [TOTAL_W-1:0]  total;
    } t_minute_verdict;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [COUNT_W-1:0]  i_error_count = '0;
    logic                i_start_of_day = 1'b0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic                o_decision_valid;
    logic                o_anomaly;
    logic [MINUTE_W-1:0] o_minute_index;
    logic [BASE_W-1:0]   o_baseline_sum;
    logic [TOTAL_W-1:0]  o_anomaly_total;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]    i_cfg_data = '0;

    moving_baseline_spike_detector #(
        .WINDOW     (WINDOW),
        .DAY_LENGTH (DAY_LEN)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_error_count    (i_error_count),
        .i_start_of_day   (i_start_of_day),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_decision_valid (o_decision_valid),
        .o_anomaly        (o_anomaly),
        .o_minute_index   (o_minute_index),
        .o_baseline_sum   (o_baseline_sum),
        .o_anomaly_total  (o_anomaly_total),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Samples waiting to be driven and verdicts waiting to come back.
    t_minute_sample  pending_minutes[$];
    t_minute_verdict predicted_verdicts[$];

    // Detector state as the scoreboard sees it.
    logic [COUNT_W-1:0]         hist [WINDOW];
    logic [$clog2(WINDOW)-1:0]  slot = '0;
    logic [31:0]                win_sum = 0;
    logic [31:0]                minute_no = 0;
    logic [31:0]                flagged_today = 0;
    logic [CFG_W-1:0]           thr_cfg = mbsd_pkg::MIN_THRESHOLD_RST;
    logic [CFG_W-1:0]           gain_cfg = mbsd_pkg::SPIKE_MULT_RST;

    // Handshake flags seen at the last rising edge.
    bit sample_xfer;
    bit result_xfer;
    bit cfg_xfer;

    int mismatches = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int days_started = 0;
    int spikes_seen = 0;
    int idle_cycles = 0;
    int stall_cycles = 0;
    int next_hold_at = 250;
    int count_level = 10;

    initial begin
        foreach (hist[k]) begin
            hist[k] = '0;
        end
    end

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Compute the verdict for one minute and advance the scoreboard state.
    task automatic score_minute(input logic [COUNT_W-1:0] cnt, input logic sod,
                                output t_minute_verdict v);
        logic [63:0] lhs;
        logic [63:0] rhs;
        logic [31:0] idx;
        logic [31:0] base_before;
        logic        hit;
        if (sod) begin
            foreach (hist[k]) begin
                hist[k] = '0;
            end
            slot = '0;
            win_sum = 0;
            minute_no = 0;
            flagged_today = 0;
        end
        idx = minute_no;
        base_before = win_sum;
        v.dec_valid = (idx >= WINDOW) && (idx < DAY_LEN);
        hit = 1'b0;
        if (v.dec_valid && cnt >= thr_cfg) begin
            lhs = 64'(cnt) * WINDOW * 256;
            rhs = 64'(base_before) * 64'(gain_cfg);
            hit = (base_before == 0) || (lhs > rhs);
        end
        if (hit && flagged_today < mbsd_pkg::TOTAL_MAX) begin
            flagged_today = flagged_today + 1;
        end
        // Past the day end the sample is dropped and the state freezes.
        if (idx < DAY_LEN) begin
            win_sum = win_sum - 32'(hist[slot]) + 32'(cnt);
            hist[slot] = cnt;
            slot = (slot == WINDOW - 1) ? '0 : slot + 1'b1;
            minute_no = idx + 1;
        end
        v.spike = hit;
        v.minute = idx[MINUTE_W-1:0];
        v.base = base_before[BASE_W-1:0];
        v.total = flagged_today[TOTAL_W-1:0];
    endtask

    // Transfer tracking, prediction, result checking and the watchdog.
    always @(posedge i_clk) begin
        t_minute_verdict want;
        t_minute_verdict got;
        sample_xfer = i_rst_n && i_valid && o_ready;
        result_xfer = i_rst_n && o_valid && i_ready;
        cfg_xfer = i_rst_n && i_cfg_valid && o_cfg_ready;

        if (result_xfer) begin
            got = '{o_decision_valid, o_anomaly, o_minute_index, o_baseline_sum,
                    o_anomaly_total};
            results_seen++;
            if (got.spike) spikes_seen++;
            if (predicted_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d arrived with nothing expected", results_seen);
                end
            end else begin
                want = predicted_verdicts.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d: expected valid=%0b anomaly=%0b minute=%0d sum=%0d total=%0d",
                                 results_seen, want.dec_valid, want.spike, want.minute,
                                 want.base, want.total);
                        $display("result %0d:   actual valid=%0b anomaly=%0b minute=%0d sum=%0d total=%0d",
                                 results_seen, got.dec_valid, got.spike, got.minute,
                                 got.base, got.total);
                    end
                end
            end
        end

        if (sample_xfer) begin
            score_minute(i_error_count, i_start_of_day, want);
            predicted_verdicts.push_back(want);
            samples_sent++;
            if (i_start_of_day) days_started++;
        end

        if (cfg_xfer) begin
            case (i_cfg_index)
                mbsd_pkg::CFG_MIN_THRESHOLD: thr_cfg = i_cfg_data;
                mbsd_pkg::CFG_SPIKE_MULT:    gain_cfg = i_cfg_data;
                default: ;
            endcase
        end

        // Stop the run when nothing moves for too long.
        if (sample_xfer || result_xfer || cfg_xfer || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("moving_baseline_spike_detector_test NOT OK");
                $finish;
            end
        end
    end

    // Sample driver: presents the next queued minute once the last one is taken, with random pauses.
    always @(negedge i_clk) begin
        t_minute_sample nxt;
        bit             pause;
        if (i_rst_n && (!i_valid || sample_xfer)) begin
            pause = !(samples_sent >= 600 && samples_sent < 900)
                    && ($urandom_range(0, 99) < 17);
            if (pending_minutes.size() != 0 && !pause) begin
                nxt = pending_minutes.pop_front();
                i_valid <= 1'b1;
                i_error_count <= nxt.count;
                i_start_of_day <= nxt.sod;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus a few long hold-offs that back up the pipe.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (stall_cycles == 0 && results_seen >= next_hold_at) begin
                stall_cycles = HOLD_LEN;
                next_hold_at += 700;
            end
            if (stall_cycles != 0) begin
                stall_cycles--;
                i_ready <= 1'b0;
            end else if (results_seen >= 600 && results_seen < 900) begin
                i_ready <= 1'b1;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= 17);
            end
        end
    end

    // Error count with a slowly drifting baseline, spikes, zeros and full scale.
    function automatic logic [COUNT_W-1:0] next_count();
        int unsigned pick;
        int unsigned v;
        if ($urandom_range(0, 63) == 0) begin
            case ($urandom_range(0, 3))
                0: count_level = $urandom_range(0, 3);
                1: count_level = $urandom_range(4, 60);
                2: count_level = $urandom_range(100, 3000);
                default: count_level = $urandom_range(8000, 40000);
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) v = 0;
        else if (pick < 12) v = 65535;
        else if (pick < 24) v = count_level * $urandom_range(2, 6) + 1;
        else v = $urandom_range(count_level / 2, count_level + count_level / 2);
        if (v > 65535) v = 65535;
        return v[COUNT_W-1:0];
    endfunction

    task automatic push_minute(input logic [COUNT_W-1:0] cnt, input logic sod);
        pending_minutes.push_back('{cnt, sod});
    endtask

    task automatic load_samples(input int n, input int sod_one_in, input bit open_day);
        logic sod;
        for (int i = 0; i < n; i++) begin
            sod = (open_day && i == 0)
                  || (sod_one_in != 0 && $urandom_range(1, sod_one_in) == 1);
            push_minute(next_count(), sod);
        end
    endtask

    task automatic wait_drained();
        while (pending_minutes.size() != 0 || i_valid || predicted_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // One register write; valid holds until the transfer.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] gain);
        wait_drained();
        write_reg(mbsd_pkg::CFG_MIN_THRESHOLD, thr);
        write_reg(mbsd_pkg::CFG_SPIKE_MULT, gain);
    endtask

    // Stimulus sequence.
    initial begin
        logic [CFG_W-1:0] day_thr [8];
        logic [CFG_W-1:0] day_gain [8];
        day_thr  = '{16'd5,   16'd1,   16'd0,      16'hFFFF, 16'd0, 16'd0, 16'd10,   16'd3};
        day_gain = '{16'd768, 16'd256, 16'hFFFF,   16'd0,    16'd0, 16'd0, 16'd1024, 16'd512};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: warm-up, empty baseline, threshold edge, exact tie, full scale.
        push_minute(16'd0, 1'b1);
        repeat (WINDOW - 1) push_minute(16'd0, 1'b0);
        push_minute(16'd5, 1'b0);
        push_minute(16'd4, 1'b0);
        push_minute(16'hFFFF, 1'b0);
        push_minute(16'd3, 1'b1);
        repeat (WINDOW - 1) push_minute(16'd3, 1'b0);
        push_minute(16'd9, 1'b0);
        push_minute(16'hFFFF, 1'b0);

        // Short days with frequent day restarts under extreme and random settings.
        set_config(16'd0, 16'd0);
        load_samples(100, 40, 1'b0);
        set_config(16'hFFFF, 16'hFFFF);
        load_samples(100, 40, 1'b0);
        set_config(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 2048)));
        load_samples(100, 40, 1'b0);

        // One long day, with settings changed along the way.
        for (int p = 0; p < 8; p++) begin
            if (p == 4 || p == 5) begin
                day_thr[p] = CFG_W'($urandom_range(0, 40));
                day_gain[p] = CFG_W'($urandom_range(128, 2048));
            end
            set_config(day_thr[p], day_gain[p]);
            if (p == 4) begin
                write_reg(CFG_UNUSED_A, CFG_W'($urandom_range(0, 65535)));
                write_reg(CFG_UNUSED_B, CFG_W'($urandom_range(0, 65535)));
            end
            load_samples(90, 0, p == 0);
        end

        // A fresh day restarts the history.
        set_config(CFG_W'($urandom_range(0, 40)), CFG_W'($urandom_range(0, 2048)));
        load_samples(20, 0, 1'b1);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (predicted_verdicts.size() != 0) begin
            $display("%0d expected results never arrived", predicted_verdicts.size());
            mismatches += predicted_verdicts.size();
        end

        $display("Run covered %0d minutes across %0d day starts; %0d flagged as spikes.",
                 samples_sent, days_started, spikes_seen);
        $display("Warm-up, empty baselines, ties and extreme settings checked; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("moving_baseline_spike_detector_test OK");
        end else begin
            $display("moving_baseline_spike_detector_test NOT OK");
        end
        $finish;
    end

endmodule
